// ----- sv/ppmd_pkg.sv -----
// Package for the PPM frame channel decoder: request opcodes, event kinds,
// the result record and register constants. No dependencies.
package ppmd_pkg;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_EDGE = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  typedef enum logic [1:0] {
    EV_SYNC    = 2'd0,
    EV_CAPTURE = 2'd1,
    EV_IGNORED = 2'd2,
    EV_READ    = 2'd3
  } event_kind_e;

  typedef struct packed {
    event_kind_e event_kind;
    logic [2:0]  channel_index;
    logic [15:0] pulse_width;
    logic        frame_done;
  } result_t;

  localparam int          ADDR_W             = 3;
  localparam logic        REG_SYNC_THRESHOLD = 1'b0;
  localparam logic [15:0] SYNC_THRESHOLD_RST = 16'd3000;

endpackage

// ----- sv/ppmd_if.sv -----
// Valid/ready channel interfaces of the PPM frame channel decoder:
// the request channel and the result channel. Depends on ppmd_pkg.
interface ppmd_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [2:0] read_channel;

  modport source (output valid, output opcode, output read_channel, input ready);
  modport sink   (input valid, input opcode, input read_channel, output ready);
endinterface

interface ppmd_rsp_if;
  logic                  valid;
  logic                  ready;
  ppmd_pkg::event_kind_e event_kind;
  logic [2:0]            channel_index;
  logic [15:0]           pulse_width;
  logic                  frame_done;

  modport source (output valid, output event_kind, output channel_index,
                  output pulse_width, output frame_done, input ready);
  modport sink   (input valid, input event_kind, input channel_index,
                  input pulse_width, input frame_done, output ready);
endinterface

// ----- sv/ppmd_core.sv -----
// Decode core: interval counter, frame tracking and channel width store.
// Produces one result record per edge or read request. Depends on ppmd_pkg.
module ppmd_core #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [1:0]        opcode_i,
  input  logic [2:0]        read_channel_i,
  input  logic [15:0]       sync_threshold_i,
  output logic              res_valid_o,
  output ppmd_pkg::result_t res_o,
  output logic              frame_active_o
);

  localparam int CW = $clog2(NUM_CHANNELS);
  localparam int IW = (CW > 3) ? CW : 3;

  logic [15:0]   interval_q, interval_d;
  logic          active_q, active_d;
  logic [CW-1:0] chan_q, chan_d;
  logic [15:0]   width_q [NUM_CHANNELS];
  logic          wr_en;
  logic [IW-1:0] rd_ext;
  logic          rd_in_range;
  logic          last_chan;

  assign rd_ext      = IW'(read_channel_i);
  assign rd_in_range = 32'(read_channel_i) < NUM_CHANNELS;
  assign last_chan   = chan_q == CW'(NUM_CHANNELS - 1);

  always_comb begin
    interval_d          = interval_q;
    active_d            = active_q;
    chan_d              = chan_q;
    wr_en               = 1'b0;
    res_valid_o         = 1'b0;
    res_o.event_kind    = ppmd_pkg::EV_IGNORED;
    res_o.channel_index = 3'd0;
    res_o.pulse_width   = interval_q;
    res_o.frame_done    = 1'b0;
    unique case (opcode_i)
      ppmd_pkg::OP_TICK: begin
        if (interval_q != 16'hFFFF) begin
          interval_d = interval_q + 16'd1;
        end
      end
      ppmd_pkg::OP_EDGE: begin
        res_valid_o = 1'b1;
        interval_d  = '0;
        if (interval_q > sync_threshold_i) begin
          res_o.event_kind = ppmd_pkg::EV_SYNC;
          active_d         = 1'b1;
          chan_d           = '0;
        end else if (active_q) begin
          res_o.event_kind    = ppmd_pkg::EV_CAPTURE;
          res_o.channel_index = 3'(chan_q);
          res_o.frame_done    = last_chan;
          wr_en               = 1'b1;
          if (last_chan) begin
            active_d = 1'b0;
          end else begin
            chan_d = chan_q + CW'(1);
          end
        end
      end
      ppmd_pkg::OP_READ: begin
        res_valid_o         = 1'b1;
        res_o.event_kind    = ppmd_pkg::EV_READ;
        res_o.channel_index = read_channel_i;
        res_o.pulse_width   = rd_in_range ? width_q[rd_ext[CW-1:0]] : 16'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= '0;
      active_q   <= 1'b0;
      chan_q     <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        width_q[i] <= '0;
      end
    end else if (accept_i) begin
      interval_q <= interval_d;
      active_q   <= active_d;
      chan_q     <= chan_d;
      if (wr_en) begin
        width_q[chan_q] <= interval_q;
      end
    end
  end

  assign frame_active_o = active_q;

endmodule

// ----- sv/ppm_frame_channel_decoder.sv -----
// Top level of the PPM frame channel decoder: request/result channels,
// two-entry result buffer and APB threshold register.
// Depends on ppmd_pkg, ppmd_req_if, ppmd_rsp_if and ppmd_core.
//
// Usage: each request on req_i carries an opcode: a tick advances the
// saturating interval counter, a rising edge classifies the interval since
// the previous edge (sync, channel capture or ignored), a read returns a
// stored channel width. Ticks and the unused opcode produce no result; every
// other request produces exactly one result on rsp_o.
// Each result goes to the result register, or to the skid entry if rsp_o
// stalls. Throughput: one request per cycle while req_i.ready is high, set by
// the single decode stage between the request port and the result register.
// A result register plus one skid entry buffer the results; req_i.ready drops
// only while both hold a result, i.e. after rsp_o has stalled for a result
// and a second one has arrived behind it.
// The sync threshold lives at APB byte address 0 (paddr bit 2 clear).
// Reset clears the counter, the frame state and all stored widths, empties
// the result buffer and sets the threshold to 3000 ticks.
module ppm_frame_channel_decoder #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ppmd_req_if.sink                    req_i,
  ppmd_rsp_if.source                  rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ppmd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic              accept;
  logic              pop;
  logic              push;
  logic              res_valid;
  ppmd_pkg::result_t res;
  logic              frame_active;
  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  ppmd_pkg::result_t out_q, out_d;
  ppmd_pkg::result_t skid_q, skid_d;
  logic [15:0]       thr_q, thr_d;
  logic              cfg_wr;

  assign req_i.ready = !skid_valid_q;
  assign accept      = req_i.valid && !skid_valid_q;
  assign pop         = out_valid_q && rsp_o.ready;
  assign push        = accept && res_valid;

  ppmd_core #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_core (
    .clk_i,
    .rst_ni,
    .accept_i        (accept),
    .opcode_i        (req_i.opcode),
    .read_channel_i  (req_i.read_channel),
    .sync_threshold_i(thr_q),
    .res_valid_o     (res_valid),
    .res_o           (res),
    .frame_active_o  (frame_active)
  );

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (out_valid_q && !pop) begin
      if (push) begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else begin
      out_valid_d = push;
      if (push) begin
        out_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.event_kind    = out_q.event_kind;
  assign rsp_o.channel_index = out_q.channel_index;
  assign rsp_o.pulse_width   = out_q.pulse_width;
  assign rsp_o.frame_done    = out_q.frame_done;

  assign cfg_wr = psel && penable && pwrite
               && (paddr[2] == ppmd_pkg::REG_SYNC_THRESHOLD);
  assign thr_d  = cfg_wr ? pwdata[15:0] : thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ppmd_pkg::SYNC_THRESHOLD_RST;
    end else begin
      thr_q <= thr_d;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ppmd_pkg::REG_SYNC_THRESHOLD) ? {16'd0, thr_q} : 32'd0;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  a_done_only_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.frame_done) |-> (rsp_o.event_kind == ppmd_pkg::EV_CAPTURE))
    else $error("frame_done on a non-capture result");

  a_sync_opens_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && (res.event_kind == ppmd_pkg::EV_SYNC)) |=> frame_active)
    else $error("sync did not open a frame");
`endif

endmodule
